// ===== hw/rtl/ripple_wave_propagate_unit_defines.svh =====
// Assertion macros used by the controller of the ripple wave propagate unit.
`ifndef RIPPLE_WAVE_PROPAGATE_UNIT_DEFINES_SVH
`define RIPPLE_WAVE_PROPAGATE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RWP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RWP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rwp_pkg.sv =====
// Shared constants, codes and types of the ripple wave propagate unit.
package rwp_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int PLANE_CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(PLANE_CELLS);

    localparam int DIM_W      = 9;
    localparam int SHIFT_W    = 5;
    localparam int CELL_W     = 16;
    localparam int IDX_W      = 16;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int PROD_W     = 2 * DIM_W;
    localparam int CARRY_W    = CELL_W + 1;
    localparam int SUM_W      = CELL_W + 4;
    localparam int VAL_W      = CELL_W + 3;

    localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POKE    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_SHIFT = 2'd2;

    localparam logic [SHIFT_W-1:0] DECAY_SHIFT_RESET = 5'd4;

    localparam int UOP_W = 5;
    localparam logic [UOP_W-1:0] U_NOP   = 5'd0;
    localparam logic [UOP_W-1:0] U_CAP   = 5'd1;
    localparam logic [UOP_W-1:0] U_CLR   = 5'd2;
    localparam logic [UOP_W-1:0] U_INIT0 = 5'd3;
    localparam logic [UOP_W-1:0] U_INIT1 = 5'd4;
    localparam logic [UOP_W-1:0] U_INIT2 = 5'd5;
    localparam logic [UOP_W-1:0] U_ROW0  = 5'd6;
    localparam logic [UOP_W-1:0] U_ROW1  = 5'd7;
    localparam logic [UOP_W-1:0] U_ROW2  = 5'd8;
    localparam logic [UOP_W-1:0] U_ROW3  = 5'd9;
    localparam logic [UOP_W-1:0] U_ROW4  = 5'd10;
    localparam logic [UOP_W-1:0] U_SKIP  = 5'd11;
    localparam logic [UOP_W-1:0] U_C0    = 5'd12;
    localparam logic [UOP_W-1:0] U_C1    = 5'd13;
    localparam logic [UOP_W-1:0] U_C2    = 5'd14;
    localparam logic [UOP_W-1:0] U_C3    = 5'd15;
    localparam logic [UOP_W-1:0] U_C4    = 5'd16;
    localparam logic [UOP_W-1:0] U_C5    = 5'd17;
    localparam logic [UOP_W-1:0] U_PK0   = 5'd18;
    localparam logic [UOP_W-1:0] U_PK1   = 5'd19;
    localparam logic [UOP_W-1:0] U_RD0   = 5'd20;
    localparam logic [UOP_W-1:0] U_RD1   = 5'd21;
    localparam logic [UOP_W-1:0] U_FIN   = 5'd22;

    typedef struct packed {
        logic [UOP_W-1:0] uop;
    } t_dp_cmd;

    typedef struct packed {
        logic             adv_ok;
        logic             acc_ok;
        logic [REQ_W-1:0] req;
        logic             more_rows;
        logic             has_cells;
        logic             last_in_row;
        logic             clr_last;
    } t_dp_stat;

endpackage

// ===== hw/rtl/rwp_req_if.sv =====
// Request channel interface of the ripple wave propagate unit.
interface rwp_req_if;
    logic                              valid;
    logic                              ready;
    logic [rwp_pkg::REQ_W-1:0]         req_type;
    logic [rwp_pkg::IDX_W-1:0]         cell_index;
    logic signed [rwp_pkg::CELL_W-1:0] poke_delta;
    logic                              read_buffer;

    modport source (output valid, req_type, cell_index, poke_delta, read_buffer,
                    input ready);
    modport sink (input valid, req_type, cell_index, poke_delta, read_buffer,
                  output ready);
endinterface

// ===== hw/rtl/rwp_rsp_if.sv =====
// Response channel interface of the ripple wave propagate unit.
interface rwp_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              status;
    logic                              settled;
    logic signed [rwp_pkg::CELL_W-1:0] cell_value;

    modport source (output valid, status, settled, cell_value, input ready);
    modport sink (input valid, status, settled, cell_value, output ready);
endinterface

// ===== hw/rtl/rwp_ram.sv =====
// Generic single-port RAM with registered read data.
module rwp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                     i_we,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/rwp_dp.sv =====
// Datapath: configuration, both height buffers, cursor arithmetic and the cell update.
module rwp_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rwp_pkg::t_dp_cmd                  i_cmd,
    output rwp_pkg::t_dp_stat                 o_stat,
    input  logic [rwp_pkg::REQ_W-1:0]         i_req_type,
    input  logic [rwp_pkg::IDX_W-1:0]         i_cell_index,
    input  logic signed [rwp_pkg::CELL_W-1:0] i_poke_delta,
    input  logic                              i_read_buffer,
    input  logic                              i_cfg_we,
    input  logic [rwp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rwp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_status,
    output logic                              o_settled,
    output logic signed [rwp_pkg::CELL_W-1:0] o_cell_value
);
    import rwp_pkg::*;

    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [SHIFT_W-1:0] r_shift;
    logic               r_active;
    logic [ADDR_W-1:0]  r_clr_cnt;

    logic [REQ_W-1:0]         r_req;
    logic [IDX_W-1:0]         r_idx;
    logic [CELL_W-1:0]        r_delta;
    logic                     r_which;
    logic [PROD_W-1:0]        r_cursor;
    logic [PROD_W-1:0]        r_row_end;
    logic signed [CARRY_W-1:0] r_up;
    logic signed [CARRY_W-1:0] r_carried;
    logic signed [CARRY_W-1:0] r_prev;
    logic signed [CARRY_W-1:0] r_cur;
    logic signed [CELL_W-1:0] r_left;
    logic signed [CELL_W-1:0] r_mid;
    logic signed [CELL_W-1:0] r_right;
    logic signed [CELL_W-1:0] r_old;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [VAL_W-1:0]  r_val;
    logic                     r_all_zero;
    logic [CELL_W-1:0]        r_cell;
    logic                     r_o_status;
    logic                     r_o_settled;
    logic [CELL_W-1:0]        r_o_cell;

    logic [PROD_W-1:0]        w_ext;
    logic [PROD_W-1:0]        cells;
    logic [PROD_W-1:0]        last_row_start;
    logic [PROD_W-1:0]        two_w2;
    logic                     geom_ok;
    logic                     adv_ok;
    logic                     acc_ok;
    logic [PROD_W-1:0]        src_addr;
    logic [CELL_W-1:0]        rd0;
    logic [CELL_W-1:0]        rd1;
    logic [CELL_W-1:0]        a_rdata;
    logic [CELL_W-1:0]        b_rdata;
    logic signed [CELL_W-1:0] b_s;
    logic [CELL_W-1:0]        read_data;
    logic signed [VAL_W-1:0]  damp;
    logic [CELL_W-1:0]        damp16;
    logic [ADDR_W-1:0]        a_addr;
    logic [ADDR_W-1:0]        b_addr;
    logic                     a_we;
    logic                     b_we;
    logic [CELL_W-1:0]        a_wdata;
    logic [CELL_W-1:0]        b_wdata;
    logic [ADDR_W-1:0]        ram0_addr;
    logic [ADDR_W-1:0]        ram1_addr;
    logic                     ram0_we;
    logic                     ram1_we;
    logic [CELL_W-1:0]        ram0_wdata;
    logic [CELL_W-1:0]        ram1_wdata;

    assign w_ext          = PROD_W'(r_width);
    assign cells          = w_ext * PROD_W'(r_height);
    assign last_row_start = cells - w_ext;
    assign two_w2         = (w_ext << 1) + PROD_W'(2);
    assign geom_ok   = (r_width != '0) && (r_height != '0) &&
                       (int'(r_width) <= MAX_WIDTH) && (int'(r_height) <= MAX_HEIGHT);
    assign adv_ok    = geom_ok && (two_w2 < cells);
    assign acc_ok    = geom_ok && (PROD_W'(r_idx) < cells);

    assign o_stat.adv_ok      = adv_ok;
    assign o_stat.acc_ok      = acc_ok;
    assign o_stat.req         = r_req;
    assign o_stat.more_rows   = r_cursor < last_row_start;
    assign o_stat.has_cells   = r_cursor < r_row_end;
    assign o_stat.last_in_row = (r_cursor + PROD_W'(1)) >= r_row_end;
    assign o_stat.clr_last    = &r_clr_cnt;

    // The "a" side is the active buffer, the "b" side the other one.
    assign a_rdata   = r_active ? rd1 : rd0;
    assign b_rdata   = r_active ? rd0 : rd1;
    assign b_s       = signed'(b_rdata);
    assign read_data = (r_which == r_active) ? a_rdata : b_rdata;
    assign damp      = r_val - (r_val >>> r_shift);
    assign damp16    = damp[CELL_W-1:0];

    always_comb begin
        case (i_cmd.uop)
            U_INIT0: src_addr = two_w2;
            U_INIT1: src_addr = PROD_W'(2);
            U_ROW0:  src_addr = r_cursor + w_ext;
            U_ROW1:  src_addr = r_cursor - w_ext;
            U_ROW2:  src_addr = r_cursor - PROD_W'(1);
            U_C0:    src_addr = r_cursor - w_ext + PROD_W'(1);
            U_C1:    src_addr = r_cursor + w_ext + PROD_W'(1);
            U_C2:    src_addr = r_cursor + PROD_W'(1);
            default: src_addr = r_cursor;
        endcase
    end

    always_comb begin
        a_addr  = ADDR_W'(r_cursor);
        b_addr  = ADDR_W'(src_addr);
        a_we    = 1'b0;
        b_we    = 1'b0;
        a_wdata = damp16;
        b_wdata = '0;
        case (i_cmd.uop)
            U_CLR: begin
                a_addr  = r_clr_cnt;
                b_addr  = r_clr_cnt;
                a_we    = 1'b1;
                b_we    = 1'b1;
                a_wdata = '0;
            end
            U_C5: begin
                a_we = 1'b1;
            end
            U_PK0: begin
                a_addr = ADDR_W'(r_idx);
            end
            U_PK1: begin
                a_addr  = ADDR_W'(r_idx);
                a_we    = 1'b1;
                a_wdata = a_rdata + r_delta;
            end
            U_RD0: begin
                a_addr = ADDR_W'(r_idx);
                b_addr = ADDR_W'(r_idx);
            end
            default: begin
            end
        endcase
    end

    assign ram0_addr  = r_active ? b_addr : a_addr;
    assign ram1_addr  = r_active ? a_addr : b_addr;
    assign ram0_we    = r_active ? b_we : a_we;
    assign ram1_we    = r_active ? a_we : b_we;
    assign ram0_wdata = r_active ? b_wdata : a_wdata;
    assign ram1_wdata = r_active ? a_wdata : b_wdata;

    rwp_ram #(
        .WIDTH (CELL_W),
        .DEPTH (PLANE_CELLS)
    ) u_ram0 (
        .i_clk   (i_clk),
        .i_addr  (ram0_addr),
        .i_we    (ram0_we),
        .i_wdata (ram0_wdata),
        .o_rdata (rd0)
    );

    rwp_ram #(
        .WIDTH (CELL_W),
        .DEPTH (PLANE_CELLS)
    ) u_ram1 (
        .i_clk   (i_clk),
        .i_addr  (ram1_addr),
        .i_we    (ram1_we),
        .i_wdata (ram1_wdata),
        .o_rdata (rd1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= '0;
            r_height  <= '0;
            r_shift   <= DECAY_SHIFT_RESET;
            r_active  <= 1'b0;
            r_clr_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GRID_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                    CFG_GRID_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                    CFG_DECAY_SHIFT: r_shift  <= i_cfg_data[SHIFT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.uop == U_CAP && i_req_type == REQ_ADVANCE) begin
                r_active <= ~r_active;
            end
            if (i_cmd.uop == U_CLR) begin
                r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.uop)
            U_CAP: begin
                r_req      <= i_req_type;
                r_idx      <= i_cell_index;
                r_delta    <= i_poke_delta;
                r_which    <= i_read_buffer;
                r_all_zero <= 1'b1;
                r_cell     <= '0;
            end
            U_INIT1: r_up <= CARRY_W'(b_s);
            U_INIT2: begin
                r_carried <= r_up + CARRY_W'(b_s);
                r_cursor  <= w_ext + PROD_W'(1);
            end
            U_ROW1: r_up <= CARRY_W'(b_s);
            U_ROW2: begin
                r_carried <= r_up + CARRY_W'(b_s);
                r_prev    <= r_carried;
                r_row_end <= r_cursor + w_ext - PROD_W'(2);
            end
            U_ROW3: r_left <= b_s;
            U_ROW4: r_mid <= b_s;
            U_SKIP: r_cursor <= r_cursor + PROD_W'(2);
            U_C1:   r_up <= CARRY_W'(b_s);
            U_C2: begin
                r_cur     <= r_carried;
                r_carried <= r_up + CARRY_W'(b_s);
            end
            U_C3: begin
                r_right <= b_s;
                r_old   <= signed'(a_rdata);
                r_sum   <= SUM_W'(r_prev) + SUM_W'(r_cur) + SUM_W'(r_carried) +
                           SUM_W'(r_left) + SUM_W'(b_s);
            end
            U_C4: r_val <= VAL_W'(r_sum >>> 2) - VAL_W'(r_old);
            U_C5: begin
                r_prev <= r_cur;
                r_left <= r_mid;
                r_mid  <= r_right;
                if (damp16 != '0) begin
                    r_all_zero <= 1'b0;
                end
                if ((r_cursor + PROD_W'(1)) >= r_row_end) begin
                    r_cursor <= r_cursor + PROD_W'(3);
                end else begin
                    r_cursor <= r_cursor + PROD_W'(1);
                end
            end
            U_RD1: r_cell <= read_data;
            U_FIN: begin
                r_o_status  <= 1'b0;
                r_o_settled <= 1'b0;
                r_o_cell    <= '0;
                case (r_req)
                    REQ_ADVANCE: begin
                        r_o_status  <= ~adv_ok;
                        r_o_settled <= adv_ok && r_all_zero;
                    end
                    REQ_POKE: r_o_status <= ~acc_ok;
                    REQ_READ: begin
                        r_o_status <= ~acc_ok;
                        r_o_cell   <= acc_ok ? r_cell : '0;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    assign o_status     = r_o_status;
    assign o_settled    = r_o_settled;
    assign o_cell_value = signed'(r_o_cell);
endmodule

// ===== hw/rtl/rwp_ctrl.sv =====
// Controller: sequences clearing, requests, the field sweep and the result handshake.
`include "ripple_wave_propagate_unit_defines.svh"
module rwp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rwp_pkg::t_dp_stat i_stat,
    output rwp_pkg::t_dp_cmd  o_cmd
);
    import rwp_pkg::*;

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] S_CLR    = 5'd0;
    localparam logic [ST_W-1:0] S_IDLE   = 5'd1;
    localparam logic [ST_W-1:0] S_DISP   = 5'd2;
    localparam logic [ST_W-1:0] S_INIT0  = 5'd3;
    localparam logic [ST_W-1:0] S_INIT1  = 5'd4;
    localparam logic [ST_W-1:0] S_INIT2  = 5'd5;
    localparam logic [ST_W-1:0] S_ROWCHK = 5'd6;
    localparam logic [ST_W-1:0] S_ROW0   = 5'd7;
    localparam logic [ST_W-1:0] S_ROW1   = 5'd8;
    localparam logic [ST_W-1:0] S_ROW2   = 5'd9;
    localparam logic [ST_W-1:0] S_ROW3   = 5'd10;
    localparam logic [ST_W-1:0] S_ROW4   = 5'd11;
    localparam logic [ST_W-1:0] S_SKIP   = 5'd12;
    localparam logic [ST_W-1:0] S_C0     = 5'd13;
    localparam logic [ST_W-1:0] S_C1     = 5'd14;
    localparam logic [ST_W-1:0] S_C2     = 5'd15;
    localparam logic [ST_W-1:0] S_C3     = 5'd16;
    localparam logic [ST_W-1:0] S_C4     = 5'd17;
    localparam logic [ST_W-1:0] S_C5     = 5'd18;
    localparam logic [ST_W-1:0] S_PK0    = 5'd19;
    localparam logic [ST_W-1:0] S_PK1    = 5'd20;
    localparam logic [ST_W-1:0] S_RD0    = 5'd21;
    localparam logic [ST_W-1:0] S_RD1    = 5'd22;
    localparam logic [ST_W-1:0] S_FIN    = 5'd23;

    logic [ST_W-1:0] r_state;
    logic [ST_W-1:0] n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic [UOP_W-1:0] uop;
    logic            out_free;

    assign out_free   = ~r_out_valid | i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        uop     = U_NOP;
        case (r_state)
            S_CLR: begin
                uop = U_CLR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    uop     = U_CAP;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.req)
                    REQ_ADVANCE: n_state = i_stat.adv_ok ? S_INIT0 : S_FIN;
                    REQ_POKE:    n_state = i_stat.acc_ok ? S_PK0 : S_FIN;
                    REQ_READ:    n_state = i_stat.acc_ok ? S_RD0 : S_FIN;
                    default:     n_state = S_FIN;
                endcase
            end
            S_INIT0: begin
                uop     = U_INIT0;
                n_state = S_INIT1;
            end
            S_INIT1: begin
                uop     = U_INIT1;
                n_state = S_INIT2;
            end
            S_INIT2: begin
                uop     = U_INIT2;
                n_state = S_ROWCHK;
            end
            S_ROWCHK: begin
                n_state = i_stat.more_rows ? S_ROW0 : S_FIN;
            end
            S_ROW0: begin
                uop     = U_ROW0;
                n_state = S_ROW1;
            end
            S_ROW1: begin
                uop     = U_ROW1;
                n_state = S_ROW2;
            end
            S_ROW2: begin
                uop     = U_ROW2;
                n_state = S_ROW3;
            end
            S_ROW3: begin
                uop     = U_ROW3;
                n_state = S_ROW4;
            end
            S_ROW4: begin
                uop     = U_ROW4;
                n_state = i_stat.has_cells ? S_C0 : S_SKIP;
            end
            S_SKIP: begin
                uop     = U_SKIP;
                n_state = S_ROWCHK;
            end
            S_C0: begin
                uop     = U_C0;
                n_state = S_C1;
            end
            S_C1: begin
                uop     = U_C1;
                n_state = S_C2;
            end
            S_C2: begin
                uop     = U_C2;
                n_state = S_C3;
            end
            S_C3: begin
                uop     = U_C3;
                n_state = S_C4;
            end
            S_C4: begin
                uop     = U_C4;
                n_state = S_C5;
            end
            S_C5: begin
                uop     = U_C5;
                n_state = i_stat.last_in_row ? S_ROWCHK : S_C0;
            end
            S_PK0: begin
                uop     = U_PK0;
                n_state = S_PK1;
            end
            S_PK1: begin
                uop     = U_PK1;
                n_state = S_FIN;
            end
            S_RD0: begin
                uop     = U_RD0;
                n_state = S_RD1;
            end
            S_RD1: begin
                uop     = U_RD1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    uop     = U_FIN;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == S_FIN && out_free) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd.uop   = uop;
    assign o_out_valid = r_out_valid;

    `RWP_ASSERT_NEXT(a_accept_dispatch, i_in_valid && o_in_ready, r_state == S_DISP, "accepted item not dispatched")
    `RWP_ASSERT_NEXT(a_result_from_fin, !r_out_valid && r_state != S_FIN, !r_out_valid, "result raised outside finish")
    `RWP_ASSERT_NEXT(a_cell_step, r_state == S_C5, r_state == S_C0 || r_state == S_ROWCHK, "bad step after cell write")
    `RWP_ASSERT_SAME(a_clear_quiet, r_state == S_CLR, !o_in_ready && !r_out_valid, "activity during clearing")
endmodule

// ===== hw/rtl/ripple_wave_propagate_unit.sv =====
// Top level of the ripple wave propagate unit.
// Poke and read: capture, dispatch, the PK or RD states, then FIN raises the result.
// A rejected or unknown item, and an advance with bad geometry, go straight to FIN.
// Advance: INIT states, then per row ROW0-ROW4, then C0-C5 per cell or SKIP if none.
// Each interior cell takes 3 reads of the other buffer, then sum, update and write.
// After reset every cell of both buffers is cleared before the first item is taken.
module ripple_wave_propagate_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rwp_req_if.sink                           i_req,
    rwp_rsp_if.source                         o_rsp,
    input  logic                              i_cfg_we,
    input  logic [rwp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rwp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import rwp_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rwp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rwp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req_type    (i_req.req_type),
        .i_cell_index  (i_req.cell_index),
        .i_poke_delta  (i_req.poke_delta),
        .i_read_buffer (i_req.read_buffer),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_status      (o_rsp.status),
        .o_settled     (o_rsp.settled),
        .o_cell_value  (o_rsp.cell_value)
    );
endmodule
